@@ src/fbpfa_pkg.sv @@
// fbpfa_pkg: shared types and codes for the framebuffer pixel format access block
// no dependencies; used by fbpfa_codec, framebuffer_pixel_format_access and the testbench
`default_nettype none

package fbpfa_pkg;

  // default store bounds
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // configuration port
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd2;

  localparam int DIM_W = 9;
  localparam int FMT_W = 3;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 9'd256;

  // pixel formats
  localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd0;
  localparam logic [FMT_W-1:0] FMT_RGB888   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_BGR888   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGBA8888 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_BGRA8888 = 3'd4;

  // commands
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_BAD_FMT  = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // byte 0 is the lowest address of the pixel
  typedef logic [3:0][7:0] pix_bytes_t;

  // bytes per pixel, zero for formats without conversion
  function automatic logic [2:0] fmt_bytes(input logic [FMT_W-1:0] fmt);
    logic [2:0] n;
    case (fmt)
      FMT_RGB565:                 n = 3'd2;
      FMT_RGB888, FMT_BGR888:     n = 3'd3;
      FMT_RGBA8888, FMT_BGRA8888: n = 3'd4;
      default:                    n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ src/fbpfa_ram.sv @@
// fbpfa_ram: generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module fbpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ src/fbpfa_codec.sv @@
// fbpfa_codec: packs rgba into the stored byte layout and unpacks it back
// depends on fbpfa_pkg
`default_nettype none

module fbpfa_codec (
  input  wire logic [fbpfa_pkg::FMT_W-1:0] fmt,
  input  wire fbpfa_pkg::rgba_t            wr_pix,
  input  wire fbpfa_pkg::pix_bytes_t       rd_bytes,
  output      fbpfa_pkg::pix_bytes_t       wr_bytes,
  output      fbpfa_pkg::rgba_t            rd_pix
);

  logic [15:0] hw_wr;
  logic [15:0] hw_rd;

  // rgb565 truncates, little-endian halfword
  assign hw_wr = {wr_pix.red[7:3], wr_pix.green[7:2], wr_pix.blue[7:3]};
  assign hw_rd = {rd_bytes[1], rd_bytes[0]};

  always_comb begin
    wr_bytes = '0;
    case (fmt)
      fbpfa_pkg::FMT_RGB565: begin
        wr_bytes[0] = hw_wr[7:0];
        wr_bytes[1] = hw_wr[15:8];
      end
      fbpfa_pkg::FMT_RGB888: begin
        wr_bytes[0] = wr_pix.red;
        wr_bytes[1] = wr_pix.green;
        wr_bytes[2] = wr_pix.blue;
      end
      fbpfa_pkg::FMT_BGR888: begin
        wr_bytes[0] = wr_pix.blue;
        wr_bytes[1] = wr_pix.green;
        wr_bytes[2] = wr_pix.red;
      end
      fbpfa_pkg::FMT_RGBA8888: begin
        wr_bytes[0] = wr_pix.red;
        wr_bytes[1] = wr_pix.green;
        wr_bytes[2] = wr_pix.blue;
        wr_bytes[3] = wr_pix.alpha;
      end
      default: begin
        wr_bytes[0] = wr_pix.blue;
        wr_bytes[1] = wr_pix.green;
        wr_bytes[2] = wr_pix.red;
        wr_bytes[3] = wr_pix.alpha;
      end
    endcase
  end

  always_comb begin
    rd_pix = '0;
    case (fmt)
      fbpfa_pkg::FMT_RGB565: begin
        // plain left shift, no bit replication
        rd_pix.red   = {hw_rd[15:11], 3'b000};
        rd_pix.green = {hw_rd[10:5], 2'b00};
        rd_pix.blue  = {hw_rd[4:0], 3'b000};
      end
      fbpfa_pkg::FMT_RGB888: begin
        rd_pix.red   = rd_bytes[0];
        rd_pix.green = rd_bytes[1];
        rd_pix.blue  = rd_bytes[2];
      end
      fbpfa_pkg::FMT_BGR888: begin
        rd_pix.red   = rd_bytes[2];
        rd_pix.green = rd_bytes[1];
        rd_pix.blue  = rd_bytes[0];
      end
      fbpfa_pkg::FMT_RGBA8888: begin
        rd_pix.red   = rd_bytes[0];
        rd_pix.green = rd_bytes[1];
        rd_pix.blue  = rd_bytes[2];
        rd_pix.alpha = rd_bytes[3];
      end
      default: begin
        rd_pix.red   = rd_bytes[2];
        rd_pix.green = rd_bytes[1];
        rd_pix.blue  = rd_bytes[0];
        rd_pix.alpha = rd_bytes[3];
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/framebuffer_pixel_format_access.sv @@
// framebuffer_pixel_format_access: byte-wide pixel store with format conversion
// depends on fbpfa_pkg, fbpfa_codec, fbpfa_ram
//
// channel   direction  signals                               transfer
// request   in         start, busy, command, x, y, rgba      start && !busy
// result    out        done, status, *_out                   done, one cycle
// config    in         cfg_write, cfg_index, cfg_data        cfg_write
//
// after a request: address math (row multiply, then offset and byte scaling),
// then one store access per byte of the pixel (2, 3 or 4). a read then waits
// for the byte ram's registered read; an error skips the math and the store
// and goes straight to done. busy drops in the cycle done is shown.
// reset starts a clearing pass over all MAX_WIDTH*MAX_HEIGHT*4 store bytes
// (262144 by default), one byte a cycle, with busy high; config writes
// still land. the receiver of results cannot stall.
`default_nettype none

module framebuffer_pixel_format_access #(
  parameter int MAX_WIDTH  = fbpfa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fbpfa_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [fbpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fbpfa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic                             command,
  input  wire logic [8:0]                       x,
  input  wire logic [8:0]                       y,
  input  wire logic [7:0]                       red,
  input  wire logic [7:0]                       green,
  input  wire logic [7:0]                       blue,
  input  wire logic [7:0]                       alpha,
  output      logic                             done,
  output      logic [1:0]                       status,
  output      logic [7:0]                       red_out,
  output      logic [7:0]                       green_out,
  output      logic [7:0]                       blue_out,
  output      logic [7:0]                       alpha_out
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * 4;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AX_W   = ADDR_W + 2;
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int PIX_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ADDR  = 3'd3;
  localparam logic [2:0] S_XFER  = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // configuration registers
  logic [fbpfa_pkg::DIM_W-1:0] image_width;
  logic [fbpfa_pkg::DIM_W-1:0] image_height;
  logic [fbpfa_pkg::FMT_W-1:0] pixel_format;

  logic [2:0]              state;
  logic [ADDR_W-1:0]       clr_cnt;
  logic [1:0]              idx;
  logic                    cmd_q;
  logic [8:0]              x_q;
  logic [8:0]              y_q;
  logic [WW-1:0]           w_q;
  logic [fbpfa_pkg::FMT_W-1:0] fmt_q;
  logic [2:0]              bpp_q;
  logic [1:0]              st_q;
  fbpfa_pkg::rgba_t        pix_q;
  logic [PIX_W-1:0]        prod;
  logic [ADDR_W-1:0]       base;
  fbpfa_pkg::pix_bytes_t   bytes_q;
  logic                    rd_pend;
  logic [1:0]              rd_idx;

  logic [WW-1:0]           w_eff;
  logic                    h_over;
  logic                    range_err;
  logic [2:0]              bpp_cfg;
  logic                    accept;
  logic [AX_W-1:0]         pix_idx;
  logic [AX_W-1:0]         addr_next;
  logic                    last_byte;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_addr;
  logic [7:0]              ram_wdata;
  logic [7:0]              ram_rdata;

  fbpfa_pkg::pix_bytes_t   wr_bytes;
  fbpfa_pkg::rgba_t        rd_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= fbpfa_pkg::WIDTH_RST;
      image_height <= fbpfa_pkg::HEIGHT_RST;
      pixel_format <= fbpfa_pkg::FMT_RGBA8888;
    end else if (cfg_write) begin
      case (cfg_index)
        fbpfa_pkg::REG_WIDTH:  image_width  <= cfg_data;
        fbpfa_pkg::REG_HEIGHT: image_height <= cfg_data;
        fbpfa_pkg::REG_FORMAT: pixel_format <= cfg_data[fbpfa_pkg::FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate dimensions to the store bounds
  always_comb begin
    if (int'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    h_over = int'(image_height) > MAX_HEIGHT;
  end

  assign range_err = (int'(x) >= int'(w_eff)) ||
                     (h_over ? (int'(y) >= MAX_HEIGHT) : (y >= image_height));
  assign bpp_cfg   = fbpfa_pkg::fmt_bytes(pixel_format);
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  // pixel index to byte address, bpp is 2, 3 or 4
  assign pix_idx = AX_W'(prod) + AX_W'(x_q);
  always_comb begin
    case (bpp_q)
      3'd2:    addr_next = pix_idx << 1;
      3'd3:    addr_next = (pix_idx << 1) + pix_idx;
      default: addr_next = pix_idx << 2;
    endcase
  end

  assign last_byte = ({1'b0, idx} == (bpp_q - 3'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (range_err || bpp_cfg == 3'd0) begin
              state <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_ADDR;
        end
        S_ADDR: begin
          idx   <= '0;
          state <= S_XFER;
        end
        S_XFER: begin
          rd_pend <= (cmd_q == fbpfa_pkg::CMD_READ);
          idx     <= idx + 1'b1;
          if (last_byte) begin
            state <= (cmd_q == fbpfa_pkg::CMD_READ) ? S_WAIT : S_DONE;
          end
        end
        S_WAIT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request payload and address pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      x_q   <= x;
      y_q   <= y;
      w_q   <= w_eff;
      fmt_q <= pixel_format;
      bpp_q <= bpp_cfg;
      pix_q <= '{red: red, green: green, blue: blue, alpha: alpha};
      if (range_err) begin
        st_q <= fbpfa_pkg::ST_RANGE;
      end else if (bpp_cfg == 3'd0) begin
        st_q <= fbpfa_pkg::ST_BAD_FMT;
      end else begin
        st_q <= fbpfa_pkg::ST_OK;
      end
    end
    if (state == S_MUL) begin
      prod <= PIX_W'(y_q) * PIX_W'(w_q);
    end
    if (state == S_ADDR) begin
      base <= addr_next[ADDR_W-1:0];
    end
    rd_idx <= idx;
    if (rd_pend) begin
      bytes_q[rd_idx] <= ram_rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      status <= st_q;
      if (st_q == fbpfa_pkg::ST_OK && cmd_q == fbpfa_pkg::CMD_READ) begin
        red_out   <= rd_pix.red;
        green_out <= rd_pix.green;
        blue_out  <= rd_pix.blue;
        alpha_out <= rd_pix.alpha;
      end else begin
        red_out   <= '0;
        green_out <= '0;
        blue_out  <= '0;
        alpha_out <= '0;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = base;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt;
      end
      S_XFER: begin
        ram_we    = (cmd_q == fbpfa_pkg::CMD_WRITE);
        ram_addr  = base + ADDR_W'(idx);
        ram_wdata = wr_bytes[idx];
      end
      default: ;
    endcase
  end

  fbpfa_codec u_codec (
    .fmt      (fmt_q),
    .wr_pix   (pix_q),
    .rd_bytes (bytes_q),
    .wr_bytes (wr_bytes),
    .rd_pix   (rd_pix)
  );

  fbpfa_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // a result lasts exactly one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // errors and writes never return pixel data
  a_zero_chan: assert property (@(posedge clk) disable iff (rst)
    (done && (status != fbpfa_pkg::ST_OK || $past(cmd_q) == fbpfa_pkg::CMD_WRITE))
    |-> (red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0 && alpha_out == 8'd0))
    else $error("nonzero channels on a write or error result");

  // byte walk stays inside the pixel
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_XFER) |-> ({1'b0, idx} < bpp_q))
    else $error("byte index beyond pixel size");

  // the store is only written by the clearing pass or a write request
  a_we_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || cmd_q == fbpfa_pkg::CMD_WRITE))
    else $error("store written outside a write request");

endmodule

`default_nettype wire

@@ tb/framebuffer_pixel_format_access_test.sv @@
// self-checking testbench for framebuffer_pixel_format_access: directed table, then random phases
// depends on fbpfa_pkg and the block under test; predicts untyped results from its pixel store
`timescale 1ns / 100ps

module framebuffer_pixel_format_access_test;

  localparam int STORE_BYTES = fbpfa_pkg::MAX_WIDTH_DEF * fbpfa_pkg::MAX_HEIGHT_DEF * 4;
  localparam int IDLE_LIMIT = 800000;
  localparam int PHASES = 18;
  localparam int PHASE_ITEMS = 100;

  // format codes with no conversion
  localparam logic [fbpfa_pkg::FMT_W-1:0] FMT_RSVD5 = 3'd5;
  localparam logic [fbpfa_pkg::FMT_W-1:0] FMT_RSVD6 = 3'd6;
  localparam logic [fbpfa_pkg::FMT_W-1:0] FMT_RSVD7 = 3'd7;
  localparam logic [fbpfa_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    fbpfa_pkg::rgba_t px;
  } pixel_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                        kind;
    logic [fbpfa_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [fbpfa_pkg::CFG_DATA_W-1:0] reg_val;
    logic                             cmd;
    logic [8:0]                       px_x;
    logic [8:0]                       px_y;
    fbpfa_pkg::rgba_t                 color;
    bit                               typed;
    pixel_result_t                    want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [fbpfa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fbpfa_pkg::CFG_DATA_W-1:0] cfg_data;
  logic start;
  logic busy;
  logic command;
  logic [8:0] x;
  logic [8:0] y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic done;
  logic [1:0] status;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  framebuffer_pixel_format_access uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .command(command), .x(x), .y(y),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .done(done), .status(status),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out), .alpha_out(alpha_out)
  );

  // predictor state
  logic [7:0] pixel_bytes [0:STORE_BYTES-1];
  logic [fbpfa_pkg::DIM_W-1:0] cfg_w;
  logic [fbpfa_pkg::DIM_W-1:0] cfg_h;
  logic [fbpfa_pkg::FMT_W-1:0] cfg_fmt;

  pixel_result_t pending_results[$];
  stim_row_t stim_table[$];
  logic [17:0] written_xy[$];
  int mismatch_count;
  int stall_cycles;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
  endtask

  function automatic int unsigned eff_dim(input logic [fbpfa_pkg::DIM_W-1:0] v,
                                          input int unsigned lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  // computes the result of one request and applies writes to the predicted store
  function automatic pixel_result_t predict_pixel(input logic cmd, input logic [8:0] px_x,
                                                  input logic [8:0] px_y,
                                                  input fbpfa_pkg::rgba_t c);
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned bpp;
    int unsigned addr;
    logic [15:0] hw;
    pixel_result_t res;
    res = '0;
    w_eff = eff_dim(cfg_w, fbpfa_pkg::MAX_WIDTH_DEF);
    h_eff = eff_dim(cfg_h, fbpfa_pkg::MAX_HEIGHT_DEF);
    case (cfg_fmt)
      fbpfa_pkg::FMT_RGB565:                            bpp = 2;
      fbpfa_pkg::FMT_RGB888, fbpfa_pkg::FMT_BGR888:     bpp = 3;
      fbpfa_pkg::FMT_RGBA8888, fbpfa_pkg::FMT_BGRA8888: bpp = 4;
      default:                                          bpp = 0;
    endcase
    if (int'(px_x) >= w_eff || int'(px_y) >= h_eff) begin
      res.status = fbpfa_pkg::ST_RANGE;
    end else if (bpp == 0) begin
      res.status = fbpfa_pkg::ST_BAD_FMT;
    end else begin
      res.status = fbpfa_pkg::ST_OK;
      addr = (int'(px_y) * w_eff + int'(px_x)) * bpp;
      if (cmd == fbpfa_pkg::CMD_WRITE) begin
        case (cfg_fmt)
          fbpfa_pkg::FMT_RGB565: begin
            hw = {c.red[7:3], c.green[7:2], c.blue[7:3]};
            pixel_bytes[addr] = hw[7:0];
            pixel_bytes[addr+1] = hw[15:8];
          end
          fbpfa_pkg::FMT_RGB888: begin
            pixel_bytes[addr] = c.red;
            pixel_bytes[addr+1] = c.green;
            pixel_bytes[addr+2] = c.blue;
          end
          fbpfa_pkg::FMT_BGR888: begin
            pixel_bytes[addr] = c.blue;
            pixel_bytes[addr+1] = c.green;
            pixel_bytes[addr+2] = c.red;
          end
          fbpfa_pkg::FMT_RGBA8888: begin
            pixel_bytes[addr] = c.red;
            pixel_bytes[addr+1] = c.green;
            pixel_bytes[addr+2] = c.blue;
            pixel_bytes[addr+3] = c.alpha;
          end
          default: begin
            pixel_bytes[addr] = c.blue;
            pixel_bytes[addr+1] = c.green;
            pixel_bytes[addr+2] = c.red;
            pixel_bytes[addr+3] = c.alpha;
          end
        endcase
      end else begin
        case (cfg_fmt)
          fbpfa_pkg::FMT_RGB565: begin
            // no bit replication on expansion
            hw = {pixel_bytes[addr+1], pixel_bytes[addr]};
            res.px.red = {hw[15:11], 3'b000};
            res.px.green = {hw[10:5], 2'b00};
            res.px.blue = {hw[4:0], 3'b000};
          end
          fbpfa_pkg::FMT_RGB888: begin
            res.px.red = pixel_bytes[addr];
            res.px.green = pixel_bytes[addr+1];
            res.px.blue = pixel_bytes[addr+2];
          end
          fbpfa_pkg::FMT_BGR888: begin
            res.px.red = pixel_bytes[addr+2];
            res.px.green = pixel_bytes[addr+1];
            res.px.blue = pixel_bytes[addr];
          end
          fbpfa_pkg::FMT_RGBA8888: begin
            res.px.red = pixel_bytes[addr];
            res.px.green = pixel_bytes[addr+1];
            res.px.blue = pixel_bytes[addr+2];
            res.px.alpha = pixel_bytes[addr+3];
          end
          default: begin
            res.px.red = pixel_bytes[addr+2];
            res.px.green = pixel_bytes[addr+1];
            res.px.blue = pixel_bytes[addr];
            res.px.alpha = pixel_bytes[addr+3];
          end
        endcase
      end
    end
    return res;
  endfunction

  // register writes only once nothing is in flight
  task automatic write_reg(input logic [fbpfa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fbpfa_pkg::CFG_DATA_W-1:0] val);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      fbpfa_pkg::REG_WIDTH:  cfg_w = val;
      fbpfa_pkg::REG_HEIGHT: cfg_h = val;
      fbpfa_pkg::REG_FORMAT: cfg_fmt = val[fbpfa_pkg::FMT_W-1:0];
      default: ;
    endcase
  endtask

  // entered and left just after a falling edge; start stays high on return
  task automatic send_request(input stim_row_t row, input int gap);
    pixel_result_t predicted;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command = row.cmd;
    x = row.px_x;
    y = row.px_y;
    red = row.color.red;
    green = row.color.green;
    blue = row.color.blue;
    alpha = row.color.alpha;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_pixel(row.cmd, row.px_x, row.px_y, row.color);
    pending_results.push_back(row.typed ? row.want : predicted);
    @(negedge clk);
  endtask

  task automatic row_cfg(input logic [fbpfa_pkg::CFG_IDX_W-1:0] idx,
                         input logic [fbpfa_pkg::CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.reg_idx = idx;
    r.reg_val = val;
    stim_table.push_back(r);
  endtask

  task automatic row_req(input logic cmd, input logic [8:0] px_x, input logic [8:0] px_y,
                         input logic [31:0] color, input bit typed,
                         input logic [1:0] want_st, input logic [31:0] want_px);
    stim_row_t r;
    r = '{kind: ROW_REQ, default: '0};
    r.cmd = cmd;
    r.px_x = px_x;
    r.px_y = px_y;
    r.color = color;
    r.typed = typed;
    r.want.status = want_st;
    r.want.px = want_px;
    stim_table.push_back(r);
  endtask

  function automatic logic [fbpfa_pkg::DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return 9'd0;
      1: return 9'd256;
      2: return 9'($urandom_range(257, 511));
      3, 4, 5: return 9'($urandom_range(1, 256));
      default: return 9'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [fbpfa_pkg::FMT_W-1:0] pick_fmt();
    if ($urandom_range(0, 9) < 8) return 3'($urandom_range(0, 4));
    return 3'($urandom_range(5, 7));
  endfunction

  // result checking
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status got %0d expected %0d", status, want.status));
        check_field("red_out", red_out, want.px.red);
        check_field("green_out", green_out, want.px.green);
        check_field("blue_out", blue_out, want.px.blue);
        check_field("alpha_out", alpha_out, want.px.alpha);
      end
    end
  end

  // watchdog on cycles with neither a request nor a result moving
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", stall_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t r;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned pick;
    logic [fbpfa_pkg::DIM_W-1:0] new_w;
    logic [fbpfa_pkg::DIM_W-1:0] new_h;
    logic [fbpfa_pkg::FMT_W-1:0] new_fmt;
    logic [5:0] upper;
    logic [17:0] xy;
    bit gapless;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    command = fbpfa_pkg::CMD_READ;
    x = '0;
    y = '0;
    red = '0;
    green = '0;
    blue = '0;
    alpha = '0;
    mismatch_count = 0;
    cfg_w = fbpfa_pkg::WIDTH_RST;
    cfg_h = fbpfa_pkg::HEIGHT_RST;
    cfg_fmt = fbpfa_pkg::FMT_RGBA8888;
    for (int i = 0; i < STORE_BYTES; i++) pixel_bytes[i] = 8'h00;

    // directed table
    row_req(fbpfa_pkg::CMD_READ, 9'd0, 9'd0, 32'h0, 1, fbpfa_pkg::ST_OK, 32'h0);
    row_req(fbpfa_pkg::CMD_READ, 9'd255, 9'd255, 32'hffffffff, 1, fbpfa_pkg::ST_OK, 32'h0);
    row_req(fbpfa_pkg::CMD_READ, 9'd256, 9'd0, 32'h0, 1, fbpfa_pkg::ST_RANGE, 32'h0);
    row_req(fbpfa_pkg::CMD_WRITE, 9'd0, 9'd256, 32'hffffffff, 1, fbpfa_pkg::ST_RANGE, 32'h0);
    row_req(fbpfa_pkg::CMD_READ, 9'd511, 9'd511, 32'h0, 1, fbpfa_pkg::ST_RANGE, 32'h0);
    row_req(fbpfa_pkg::CMD_WRITE, 9'd255, 9'd255, 32'hffffffff, 1, fbpfa_pkg::ST_OK, 32'h0);
    row_req(fbpfa_pkg::CMD_READ, 9'd255, 9'd255, 32'h0, 1, fbpfa_pkg::ST_OK, 32'hffffffff);
    row_req(fbpfa_pkg::CMD_WRITE, 9'd0, 9'd0, 32'h12345678, 1, fbpfa_pkg::ST_OK, 32'h0);
    row_req(fbpfa_pkg::CMD_READ, 9'd0, 9'd0, 32'h0, 0, fbpfa_pkg::ST_OK, 32'h0);
    // stored bytes read back under another format
    row_cfg(fbpfa_pkg::REG_FORMAT, {6'd0, fbpfa_pkg::FMT_BGRA8888});
    row_req(fbpfa_pkg::CMD_READ, 9'd0, 9'd0, 32'h0, 0, fbpfa_pkg::ST_OK, 32'h0);
    row_cfg(fbpfa_pkg::REG_FORMAT, {6'd0, FMT_RSVD5});
    row_req(fbpfa_pkg::CMD_READ, 9'd1, 9'd1, 32'h0, 1, fbpfa_pkg::ST_BAD_FMT, 32'h0);
    row_req(fbpfa_pkg::CMD_WRITE, 9'd2, 9'd2, 32'haabbccdd, 1, fbpfa_pkg::ST_BAD_FMT, 32'h0);
    // range check wins over a bad format
    row_req(fbpfa_pkg::CMD_READ, 9'd300, 9'd1, 32'h0, 1, fbpfa_pkg::ST_RANGE, 32'h0);
    row_cfg(fbpfa_pkg::REG_FORMAT, {6'h3f, FMT_RSVD7});
    row_req(fbpfa_pkg::CMD_READ, 9'd3, 9'd3, 32'h0, 1, fbpfa_pkg::ST_BAD_FMT, 32'h0);
    row_cfg(fbpfa_pkg::REG_FORMAT, {6'd0, fbpfa_pkg::FMT_RGB565});
    row_req(fbpfa_pkg::CMD_WRITE, 9'd3, 9'd0, 32'hffffffff, 1, fbpfa_pkg::ST_OK, 32'h0);
    row_req(fbpfa_pkg::CMD_READ, 9'd3, 9'd0, 32'h0, 1, fbpfa_pkg::ST_OK, 32'hf8fcf800);
    row_req(fbpfa_pkg::CMD_WRITE, 9'd4, 9'd0, 32'h07030700, 0, fbpfa_pkg::ST_OK, 32'h0);
    row_req(fbpfa_pkg::CMD_READ, 9'd4, 9'd0, 32'h0, 0, fbpfa_pkg::ST_OK, 32'h0);
    row_cfg(fbpfa_pkg::REG_FORMAT, {6'd0, fbpfa_pkg::FMT_RGB888});
    row_req(fbpfa_pkg::CMD_WRITE, 9'd5, 9'd1, 32'h01020304, 0, fbpfa_pkg::ST_OK, 32'h0);
    row_cfg(fbpfa_pkg::REG_FORMAT, {6'd0, fbpfa_pkg::FMT_BGR888});
    row_req(fbpfa_pkg::CMD_READ, 9'd5, 9'd1, 32'h0, 0, fbpfa_pkg::ST_OK, 32'h0);
    row_cfg(fbpfa_pkg::REG_WIDTH, 9'd0);
    row_req(fbpfa_pkg::CMD_READ, 9'd0, 9'd0, 32'h0, 1, fbpfa_pkg::ST_RANGE, 32'h0);
    // oversized width saturates
    row_cfg(fbpfa_pkg::REG_WIDTH, 9'd511);
    row_cfg(fbpfa_pkg::REG_HEIGHT, 9'd1);
    row_req(fbpfa_pkg::CMD_READ, 9'd255, 9'd0, 32'h0, 0, fbpfa_pkg::ST_OK, 32'h0);
    row_req(fbpfa_pkg::CMD_READ, 9'd0, 9'd1, 32'h0, 1, fbpfa_pkg::ST_RANGE, 32'h0);
    row_cfg(REG_SPARE, 9'h1a5);

    repeat (4) @(negedge clk);
    rst = 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG)
        write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
      else
        send_request(stim_table[i], $urandom_range(0, 8));
    end

    // random phases, each under one register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin new_w = 9'd256; new_h = 9'd256; new_fmt = fbpfa_pkg::FMT_RGBA8888; end
        1: begin new_w = 9'd1; new_h = 9'd1; new_fmt = fbpfa_pkg::FMT_RGB565; end
        2: begin new_w = 9'd511; new_h = 9'd511; new_fmt = fbpfa_pkg::FMT_BGRA8888; end
        3: begin new_w = 9'd2; new_h = 9'd3; new_fmt = fbpfa_pkg::FMT_RGB888; end
        4: begin new_w = 9'd300; new_h = 9'd7; new_fmt = fbpfa_pkg::FMT_BGR888; end
        5: begin new_w = 9'd5; new_h = 9'd4; new_fmt = FMT_RSVD6; end
        default: begin
          // sometimes keep the geometry so stored pixels get reinterpreted
          if ($urandom_range(0, 2) == 0) begin
            new_w = cfg_w;
            new_h = cfg_h;
          end else begin
            new_w = pick_dim();
            new_h = pick_dim();
          end
          new_fmt = pick_fmt();
        end
      endcase
      if (new_w != cfg_w || new_h != cfg_h) written_xy.delete();
      write_reg(fbpfa_pkg::REG_WIDTH, new_w);
      write_reg(fbpfa_pkg::REG_HEIGHT, new_h);
      upper = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'd0;
      write_reg(fbpfa_pkg::REG_FORMAT, {upper, new_fmt});
      if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE, 9'($urandom_range(0, 511)));
      w_eff = eff_dim(cfg_w, fbpfa_pkg::MAX_WIDTH_DEF);
      h_eff = eff_dim(cfg_h, fbpfa_pkg::MAX_HEIGHT_DEF);
      gapless = ($urandom_range(0, 3) == 0);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = '{kind: ROW_REQ, default: '0};
        r.cmd = 1'($urandom_range(0, 1));
        r.color = $urandom();
        pick = $urandom_range(0, 99);
        if (w_eff == 0 || h_eff == 0 || pick < 15) begin
          r.px_x = 9'($urandom_range(0, 511));
          r.px_y = 9'($urandom_range(0, 511));
        end else if (written_xy.size() != 0 && pick < 60) begin
          xy = written_xy[$urandom_range(0, written_xy.size() - 1)];
          r.px_x = xy[17:9];
          r.px_y = xy[8:0];
        end else begin
          r.px_x = 9'($urandom_range(0, w_eff - 1));
          r.px_y = 9'($urandom_range(0, h_eff - 1));
        end
        if (r.cmd == fbpfa_pkg::CMD_WRITE && int'(r.px_x) < w_eff && int'(r.px_y) < h_eff) begin
          written_xy.push_back({r.px_x, r.px_y});
          if (written_xy.size() > 32) void'(written_xy.pop_front());
        end
        send_request(r, gapless ? 0 : $urandom_range(0, 8));
      end
    end

    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/fbpfa_pkg.sv
src/fbpfa_ram.sv
src/fbpfa_codec.sv
src/framebuffer_pixel_format_access.sv
tb/framebuffer_pixel_format_access_test.sv
